FILE: hdl/firc_pkg.sv
// Shared types and constants for the firewall rule classifier.
// No dependencies; all modules refer to it by scoped names, the interfaces do not use it.
package firc_pkg;

	// Item codes on the action field
	localparam logic ACT_CLASSIFY = 1'b0;
	localparam logic ACT_WRITE    = 1'b1;

	// Protocol codes; the first three also select a rule table
	localparam logic [1:0] PROTO_TCP   = 2'd0;
	localparam logic [1:0] PROTO_UDP   = 2'd1;
	localparam logic [1:0] PROTO_ICMP  = 2'd2;
	localparam logic [1:0] PROTO_OTHER = 2'd3;

	localparam int NUM_TABLES = 3;

	// TCP flags: ECE and CWR are don't-care, the rest must be a lone SYN
	localparam logic [7:0] TCP_FLAGS_CHECKED = 8'h3F;
	localparam logic [7:0] TCP_FLAG_SYN      = 8'h02;

	// Stored part of one rule (the valid bit lives in flops beside the memory)
	typedef struct packed {
		logic        outgoing;
		logic [15:0] port;
		logic [31:0] prv_addr;
		logic [31:0] prv_mask;
		logic [31:0] pub_addr;
		logic [31:0] pub_mask;
	} rule_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

FILE: hdl/firc_pkt_if.sv
// Input channel of the classifier: valid/ready plus one packet or rule word.
// Depends on nothing.
interface firc_pkt_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [1:0]  protocol;
	logic [7:0]  tcp_flags;
	logic        outgoing;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] dst_port;
	logic [3:0]  rule_slot;
	logic        rule_enable;
	logic [31:0] private_mask;
	logic [31:0] public_mask;

	modport source (
		output valid, action, protocol, tcp_flags, outgoing, src_addr, dst_addr,
		       dst_port, rule_slot, rule_enable, private_mask, public_mask,
		input  ready
	);
	modport sink (
		input  valid, action, protocol, tcp_flags, outgoing, src_addr, dst_addr,
		       dst_port, rule_slot, rule_enable, private_mask, public_mask,
		output ready
	);
endinterface

FILE: hdl/firc_res_if.sv
// Result channel of the classifier: valid/ready plus one verdict word.
// Depends on nothing.
interface firc_res_if;
	logic valid;
	logic ready;
	logic allowed;
	logic write_done;

	modport source (output valid, allowed, write_done, input ready);
	modport sink (input valid, allowed, write_done, output ready);
endinterface

FILE: hdl/firewall_rule_classifier_core.sv
// Firewall rule classifier: three masked allow-rule tables (TCP, UDP, ICMP).
// Rule write: the word goes through the FINISH state into the result register, and the next
// word is taken in the cycle that result appears. Classify: one rule compared per cycle through
// the rule memory's single read port, stopping early on a match; rejected protocols and non-SYN
// TCP finish like writes. A held result stalls the input.
// Reset clears all rule valid bits and the result valid bit; no clearing pass.
module firewall_rule_classifier_core #(
	parameter int RULES_PER_TABLE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	firc_pkt_if.sink    pkt,
	firc_res_if.source  res
);

	localparam int NUM_ENTRIES = firc_pkg::NUM_TABLES * RULES_PER_TABLE;
	localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int IDX_W       = $clog2(RULES_PER_TABLE + 1);

	firc_pkg::state_t state_q, state_d;

	// Packet under classification
	logic                  dir_q;
	logic [15:0]           port_q;
	logic [31:0]           prv_q;
	logic [31:0]           pub_q;
	logic [ADDR_W-1:0]     base_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  is_write_q;
	logic                  hit_q;

	// Scan pipeline
	logic                  issue;
	logic                  issue_s1;
	logic                  last_s1;
	logic [ADDR_W-1:0]     rd_addr;
	firc_pkg::rule_entry_t rd_entry_s1;
	logic                  rd_valid_s1;
	logic                  rule_hit;
	logic                  scan_end;

	// Output register
	logic                  res_valid_q;
	logic                  res_allowed_q;
	logic                  res_write_done_q;
	logic                  res_load;

	// Accept decode
	logic                  accept;
	logic                  is_write;
	logic                  tbl_ok;
	logic                  slot_ok;
	logic                  syn_ok;
	logic                  need_scan;
	logic [ADDR_W-1:0]     tbl_base;
	logic [ADDR_W-1:0]     wr_addr;
	logic                  wr_en;
	firc_pkg::rule_entry_t wr_entry;

	assign accept   = pkt.valid && pkt.ready;
	assign is_write = (pkt.action == firc_pkg::ACT_WRITE);
	assign tbl_ok   = (pkt.protocol != firc_pkg::PROTO_OTHER);
	assign slot_ok  = (32'(pkt.rule_slot) < 32'(RULES_PER_TABLE));
	assign syn_ok   = (pkt.protocol != firc_pkg::PROTO_TCP) ||
	                  ((pkt.tcp_flags & firc_pkg::TCP_FLAGS_CHECKED) == firc_pkg::TCP_FLAG_SYN);
	assign need_scan = !is_write && tbl_ok && syn_ok;
	assign tbl_base = ADDR_W'(ADDR_W'(pkt.protocol) * ADDR_W'(RULES_PER_TABLE));
	assign wr_addr  = tbl_base + ADDR_W'(pkt.rule_slot);
	assign wr_en    = accept && is_write && tbl_ok && slot_ok;

	// Rule word as stored
	always_comb begin
		wr_entry.outgoing = pkt.outgoing;
		wr_entry.port     = pkt.dst_port;
		wr_entry.prv_addr = pkt.src_addr;
		wr_entry.prv_mask = pkt.private_mask;
		wr_entry.pub_addr = pkt.dst_addr;
		wr_entry.pub_mask = pkt.public_mask;
	end

	firc_rule_store #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.ADDR_W      (ADDR_W)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_entry    (wr_entry),
		.wr_valid    (pkt.rule_enable),
		.rd_addr     (rd_addr),
		.rd_entry_s1 (rd_entry_s1),
		.rd_valid_s1 (rd_valid_s1)
	);

	// Read one rule per cycle while scanning
	assign issue   = (state_q == firc_pkg::ST_SCAN) && (32'(idx_q) < 32'(RULES_PER_TABLE));
	assign rd_addr = base_q + ADDR_W'(idx_q);

	// Compare the rule read last cycle against the packet
	assign rule_hit = issue_s1 && rd_valid_s1 &&
	                  (rd_entry_s1.outgoing == dir_q) &&
	                  ((rd_entry_s1.port == 16'd0) || (rd_entry_s1.port == port_q)) &&
	                  ((rd_entry_s1.prv_addr & rd_entry_s1.prv_mask) ==
	                   (prv_q & rd_entry_s1.prv_mask)) &&
	                  ((rd_entry_s1.pub_addr & rd_entry_s1.pub_mask) ==
	                   (pub_q & rd_entry_s1.pub_mask));
	assign scan_end = rule_hit || (issue_s1 && last_s1);

	assign res_load = (state_q == firc_pkg::ST_FINISH) && (!res_valid_q || res.ready);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= firc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d   = state_q;
		pkt.ready = 1'b0;
		unique case (state_q)
			firc_pkg::ST_IDLE: begin
				pkt.ready = 1'b1;
				if (pkt.valid) begin
					state_d = need_scan ? firc_pkg::ST_SCAN : firc_pkg::ST_FINISH;
				end
			end
			firc_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = firc_pkg::ST_FINISH;
				end
			end
			firc_pkg::ST_FINISH: begin
				if (res_load) begin
					state_d = firc_pkg::ST_IDLE;
				end
			end
			default: state_d = firc_pkg::ST_IDLE;
		endcase
	end

	// Scan control flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			issue_s1 <= issue && !scan_end;
			if (accept) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Packet fields and verdict
	always_ff @(posedge clk) begin
		last_s1 <= (32'(idx_q) == 32'(RULES_PER_TABLE - 1));
		if (accept) begin
			is_write_q <= is_write;
			hit_q      <= 1'b0;
			dir_q      <= pkt.outgoing;
			port_q     <= (pkt.protocol == firc_pkg::PROTO_ICMP) ? 16'd0 : pkt.dst_port;
			prv_q      <= pkt.outgoing ? pkt.src_addr : pkt.dst_addr;
			pub_q      <= pkt.outgoing ? pkt.dst_addr : pkt.src_addr;
			base_q     <= tbl_base;
		end else if (state_q == firc_pkg::ST_SCAN && scan_end) begin
			hit_q <= rule_hit;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_allowed_q    <= hit_q && !is_write_q;
			res_write_done_q <= is_write_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.allowed    = res_allowed_q;
	assign res.write_done = res_write_done_q;

endmodule

FILE: hdl/firc_rule_store.sv
// Rule storage: synchronous single-write, single-read memory of rule entries
// with registered read, plus per-entry valid flops. Uses firc_pkg.
module firc_rule_store #(
	parameter int NUM_ENTRIES = 48,
	parameter int ADDR_W      = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [ADDR_W-1:0]      wr_addr,
	input  firc_pkg::rule_entry_t  wr_entry,
	input  logic                   wr_valid,
	input  logic [ADDR_W-1:0]      rd_addr,
	output firc_pkg::rule_entry_t  rd_entry_s1,
	output logic                   rd_valid_s1
);

	firc_pkg::rule_entry_t mem [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] valid_q;

	// Entry array: written on rule writes, read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_entry_s1 <= mem[rd_addr];
		rd_valid_s1 <= valid_q[rd_addr];
	end

	// Valid bits, cleared at reset so unwritten entries never match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= wr_valid;
		end
	end

endmodule

FILE: tb/firc_checker.sv
`timescale 1ns / 1ps
// Checker for the firewall rule classifier: watches both channels, keeps its own rule tables,
// predicts one verdict word per accepted input word and compares. Depends on firc_pkg and the
// firc_pkt_if / firc_res_if interfaces.
module firc_checker #(
	parameter int RULES_PER_TABLE = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	firc_pkt_if   pkt,
	firc_res_if   res,
	output int    fail_count,
	output int    words_pending
);

	localparam int NUM_RULES = firc_pkg::NUM_TABLES * RULES_PER_TABLE;

	typedef struct packed {
		logic allowed;
		logic write_done;
	} verdict_t;

	verdict_t              verdict_q[$];
	firc_pkg::rule_entry_t rule_mem[NUM_RULES];
	logic                  rule_live[NUM_RULES];
	int                    errors = 0;

	// Verdict for one classify word against the current tables
	function automatic logic match_packet(input logic [1:0] proto, input logic [7:0] flags,
		input logic dir, input logic [31:0] src, input logic [31:0] dst,
		input logic [15:0] dport);
		firc_pkg::rule_entry_t r;
		logic [15:0] port;
		logic [31:0] prv;
		logic [31:0] pub;
		int          base;
		logic        hit;
		hit = 1'b0;
		if (proto == firc_pkg::PROTO_OTHER)
			return 1'b0;
		// only a lone SYN gets through; ECE/CWR are don't-care
		if (proto == firc_pkg::PROTO_TCP &&
				(flags & firc_pkg::TCP_FLAGS_CHECKED) != firc_pkg::TCP_FLAG_SYN)
			return 1'b0;
		port = (proto == firc_pkg::PROTO_ICMP) ? 16'h0000 : dport;
		// incoming packets swap the private and public sides
		prv  = dir ? src : dst;
		pub  = dir ? dst : src;
		base = int'(proto) * RULES_PER_TABLE;
		for (int i = 0; i < RULES_PER_TABLE; i++) begin
			r = rule_mem[base + i];
			if (rule_live[base + i] && r.outgoing == dir
					&& (r.port == 16'h0000 || r.port == port)
					&& ((r.prv_addr ^ prv) & r.prv_mask) == 32'h0
					&& ((r.pub_addr ^ pub) & r.pub_mask) == 32'h0)
				hit = 1'b1;
		end
		return hit;
	endfunction

	task automatic note_mismatch(input string what, input logic want, input logic got);
		errors++;
		if (errors <= 10)
			$display("%0t ERROR: %s expected %0b got %0b", $realtime, what, want, got);
	endtask

	// Score results first, then log the new input word
	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		int       idx;
		if (!arst_n) begin
			verdict_q.delete();
			for (int i = 0; i < NUM_RULES; i++)
				rule_live[i] = 1'b0;
			fail_count    <= 0;
			words_pending <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (verdict_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t ERROR: result word allowed=%0b write_done=%0b with none pending",
							$realtime, res.allowed, res.write_done);
				end else begin
					want = verdict_q.pop_front();
					if (res.allowed !== want.allowed)
						note_mismatch("allowed", want.allowed, res.allowed);
					if (res.write_done !== want.write_done)
						note_mismatch("write_done", want.write_done, res.write_done);
				end
			end
			if (pkt.valid && pkt.ready) begin
				if (pkt.action == firc_pkg::ACT_WRITE) begin
					// other protocol or out-of-range slot stores nothing
					if (pkt.protocol != firc_pkg::PROTO_OTHER &&
							pkt.rule_slot < RULES_PER_TABLE) begin
						idx = int'(pkt.protocol) * RULES_PER_TABLE + int'(pkt.rule_slot);
						rule_live[idx] = pkt.rule_enable;
						rule_mem[idx]  = '{outgoing: pkt.outgoing, port: pkt.dst_port,
							prv_addr: pkt.src_addr, prv_mask: pkt.private_mask,
							pub_addr: pkt.dst_addr, pub_mask: pkt.public_mask};
					end
					verdict_q.push_back('{allowed: 1'b0, write_done: 1'b1});
				end else begin
					verdict_q.push_back('{allowed: match_packet(pkt.protocol, pkt.tcp_flags,
						pkt.outgoing, pkt.src_addr, pkt.dst_addr, pkt.dst_port),
						write_done: 1'b0});
				end
			end
			fail_count    <= errors;
			words_pending <= verdict_q.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the classifier testbench: clock, reset, rule and packet stimulus, receiver stalls,
// watchdog and verdict. Depends on firc_pkg, the channel interfaces, firc_checker and the core.
module tb_top;

	localparam int RULES          = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_LEN       = 400;

	typedef struct {
		logic        action;
		logic [1:0]  protocol;
		logic [7:0]  tcp_flags;
		logic        outgoing;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] dst_port;
		logic [3:0]  rule_slot;
		logic        rule_enable;
		logic [31:0] private_mask;
		logic [31:0] public_mask;
	} pkt_word_t;

	logic clk      = 1'b0;
	logic arst_n   = 1'b0;
	logic hold_arm = 1'b0;
	int   fail_count;
	int   words_pending;
	int   src_idle_pct  = 22;
	int   sink_idle_pct = 64;
	int   quiet_cycles  = 0;

	// Last rule written per slot, used to aim packets at real rules
	firc_pkg::rule_entry_t shadow_rules[firc_pkg::NUM_TABLES][RULES];

	firc_pkt_if pkt_bus ();
	firc_res_if res_bus ();

	firewall_rule_classifier_core #(.RULES_PER_TABLE(RULES)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_bus),
		.res    (res_bus)
	);

	firc_checker #(.RULES_PER_TABLE(RULES)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.pkt           (pkt_bus),
		.res           (res_bus),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stalls, or one long hold-off once armed
	initial begin : receiver
		int   hold_cycles;
		logic hold_used;
		hold_cycles = 0;
		hold_used   = 1'b0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_arm && !hold_used) begin
				hold_used   = 1'b1;
				hold_cycles = HOLD_LEN;
			end
			if (hold_cycles != 0) begin
				hold_cycles--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((pkt_bus.valid && pkt_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [31:0] rand_mask();
		int n;
		n = $urandom_range(0, 32);
		case ($urandom_range(0, 3))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0000_0000;
			2: return (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - n));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [15:0] rand_port();
		case ($urandom_range(0, 9))
			0, 1, 2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic pkt_word_t make_rule(input logic [1:0] proto, input logic [3:0] slot,
		input logic dir, input logic [15:0] port, input logic [31:0] prv,
		input logic [31:0] prv_mask, input logic [31:0] pub, input logic [31:0] pub_mask,
		input logic en);
		pkt_word_t w;
		w = '{action: firc_pkg::ACT_WRITE, protocol: proto, tcp_flags: 8'($urandom()),
			outgoing: dir, src_addr: prv, dst_addr: pub, dst_port: port, rule_slot: slot,
			rule_enable: en, private_mask: prv_mask, public_mask: pub_mask};
		return w;
	endfunction

	function automatic pkt_word_t make_pkt(input logic [1:0] proto, input logic [7:0] flags,
		input logic dir, input logic [31:0] src, input logic [31:0] dst,
		input logic [15:0] port);
		pkt_word_t w;
		// write-only fields carry noise on a classify word
		w = '{action: firc_pkg::ACT_CLASSIFY, protocol: proto, tcp_flags: flags, outgoing: dir,
			src_addr: src, dst_addr: dst, dst_port: port, rule_slot: 4'($urandom()),
			rule_enable: 1'($urandom()), private_mask: $urandom(), public_mask: $urandom()};
		return w;
	endfunction

	// Packet built to hit a stored rule, sometimes nudged off in one address bit, the direction or the port
	function automatic pkt_word_t aimed_packet();
		firc_pkg::rule_entry_t r;
		pkt_word_t   w;
		logic [1:0]  proto;
		logic [31:0] prv;
		logic [31:0] pub;
		logic [7:0]  flags;
		int          bit_idx;
		proto   = 2'($urandom_range(0, firc_pkg::NUM_TABLES - 1));
		r       = shadow_rules[proto][$urandom_range(0, RULES - 1)];
		prv     = (r.prv_addr & r.prv_mask) | ($urandom() & ~r.prv_mask);
		pub     = (r.pub_addr & r.pub_mask) | ($urandom() & ~r.pub_mask);
		flags   = firc_pkg::TCP_FLAG_SYN | (8'($urandom()) & ~firc_pkg::TCP_FLAGS_CHECKED);
		bit_idx = $urandom_range(0, 31);
		if ($urandom_range(0, 9) == 0)
			flags = 8'($urandom());
		w = make_pkt(proto, flags, r.outgoing, r.outgoing ? prv : pub,
			r.outgoing ? pub : prv, (r.port == 16'h0) ? 16'($urandom()) : r.port);
		case ($urandom_range(0, 9))
			0: w.src_addr[bit_idx] = ~w.src_addr[bit_idx];
			1: w.dst_addr[bit_idx] = ~w.dst_addr[bit_idx];
			2: w.outgoing = ~w.outgoing;
			3: w.dst_port = w.dst_port ^ 16'($urandom_range(1, 65535));
			default: ;
		endcase
		return w;
	endfunction

	// Mix: rule writes, aimed packets, and raw noise packets
	function automatic pkt_word_t random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return make_rule(2'($urandom()), 4'($urandom()), 1'($urandom()), rand_port(),
				$urandom(), rand_mask(), $urandom(), rand_mask(), $urandom_range(0, 6) != 0);
		else if (pick < 80)
			return aimed_packet();
		else
			return make_pkt(2'($urandom()), 8'($urandom()), 1'($urandom()), $urandom(),
				$urandom(), 16'($urandom()));
	endfunction

	// Offer one word after a random gap and hold it until taken
	task automatic send_word(input pkt_word_t w);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < src_idle_pct)
			gap++;
		if (gap != 0) begin
			pkt_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_bus.valid        <= 1'b1;
		pkt_bus.action       <= w.action;
		pkt_bus.protocol     <= w.protocol;
		pkt_bus.tcp_flags    <= w.tcp_flags;
		pkt_bus.outgoing     <= w.outgoing;
		pkt_bus.src_addr     <= w.src_addr;
		pkt_bus.dst_addr     <= w.dst_addr;
		pkt_bus.dst_port     <= w.dst_port;
		pkt_bus.rule_slot    <= w.rule_slot;
		pkt_bus.rule_enable  <= w.rule_enable;
		pkt_bus.private_mask <= w.private_mask;
		pkt_bus.public_mask  <= w.public_mask;
		@(posedge clk);
		while (!pkt_bus.ready)
			@(posedge clk);
		if (w.action == firc_pkg::ACT_WRITE && w.protocol != firc_pkg::PROTO_OTHER)
			shadow_rules[w.protocol][w.rule_slot] = '{outgoing: w.outgoing,
				port: w.dst_port, prv_addr: w.src_addr, prv_mask: w.private_mask,
				pub_addr: w.dst_addr, pub_mask: w.public_mask};
	endtask

	// Sender pauses until every verdict is back
	task automatic wait_drained();
		pkt_bus.valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		pkt_bus.valid        <= 1'b0;
		pkt_bus.action       <= firc_pkg::ACT_CLASSIFY;
		pkt_bus.protocol     <= firc_pkg::PROTO_TCP;
		pkt_bus.tcp_flags    <= 8'h00;
		pkt_bus.outgoing     <= 1'b0;
		pkt_bus.src_addr     <= 32'h0;
		pkt_bus.dst_addr     <= 32'h0;
		pkt_bus.dst_port     <= 16'h0;
		pkt_bus.rule_slot    <= 4'h0;
		pkt_bus.rule_enable  <= 1'b0;
		pkt_bus.private_mask <= 32'h0;
		pkt_bus.public_mask  <= 32'h0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Give every slot defined contents before any table scan; most stay disabled
		for (int t = 0; t < firc_pkg::NUM_TABLES; t++)
			for (int s = 0; s < RULES; s++)
				send_word(make_rule(2'(t), 4'(s), 1'($urandom()), rand_port(), $urandom(),
					rand_mask(), $urandom(), rand_mask(), $urandom_range(0, 3) == 0));

		// Directed: SYN filtering, wildcards, direction swap, port/mask extremes
		send_word(make_rule(firc_pkg::PROTO_TCP, 4'd0, 1'b1, 16'd80, 32'h0A00_0000,
			32'hFF00_0000, 32'h0, 32'h0, 1'b1));
		send_word(make_pkt(firc_pkg::PROTO_TCP, firc_pkg::TCP_FLAG_SYN, 1'b1, 32'h0A01_0203,
			32'hC0A8_0101, 16'd80));
		send_word(make_pkt(firc_pkg::PROTO_TCP, 8'hC2, 1'b1, 32'h0A01_0203, 32'hC0A8_0101,
			16'd80));
		send_word(make_pkt(firc_pkg::PROTO_TCP, 8'h12, 1'b1, 32'h0A01_0203, 32'hC0A8_0101,
			16'd80));
		send_word(make_pkt(firc_pkg::PROTO_TCP, 8'h00, 1'b1, 32'h0A01_0203, 32'hC0A8_0101,
			16'd80));
		send_word(make_pkt(firc_pkg::PROTO_TCP, 8'hFF, 1'b1, 32'h0A01_0203, 32'hC0A8_0101,
			16'd80));
		send_word(make_pkt(firc_pkg::PROTO_TCP, firc_pkg::TCP_FLAG_SYN, 1'b1, 32'h0A01_0203,
			32'hC0A8_0101, 16'd81));
		send_word(make_pkt(firc_pkg::PROTO_TCP, firc_pkg::TCP_FLAG_SYN, 1'b0, 32'hC0A8_0101,
			32'h0A01_0203, 16'd80));
		send_word(make_rule(firc_pkg::PROTO_UDP, 4'd15, 1'b0, 16'h0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1));
		send_word(make_pkt(firc_pkg::PROTO_UDP, 8'h00, 1'b0, 32'h0, 32'hFFFF_FFFF, 16'hFFFF));
		send_word(make_pkt(firc_pkg::PROTO_UDP, 8'hFF, 1'b0, 32'hFFFF_FFFF, 32'h0, 16'h0));
		send_word(make_rule(firc_pkg::PROTO_ICMP, 4'd3, 1'b1, 16'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 1'b1));
		send_word(make_pkt(firc_pkg::PROTO_ICMP, 8'hFF, 1'b1, $urandom(), $urandom(),
			16'd12345));
		send_word(make_rule(firc_pkg::PROTO_ICMP, 4'd3, 1'b1, 16'd7, 32'h0, 32'h0, 32'h0,
			32'h0, 1'b1));
		send_word(make_pkt(firc_pkg::PROTO_ICMP, 8'h00, 1'b1, $urandom(), $urandom(), 16'd7));
		send_word(make_pkt(firc_pkg::PROTO_OTHER, firc_pkg::TCP_FLAG_SYN, 1'b1, 32'h0A01_0203,
			32'h0, 16'd80));
		send_word(make_rule(firc_pkg::PROTO_OTHER, 4'd5, 1'b1, 16'd80, 32'h0, 32'h0, 32'h0,
			32'h0, 1'b1));
		// disabled write removes the TCP rule
		send_word(make_rule(firc_pkg::PROTO_TCP, 4'd0, 1'b1, 16'd80, 32'h0A00_0000,
			32'hFF00_0000, 32'h0, 32'h0, 1'b0));
		send_word(make_pkt(firc_pkg::PROTO_TCP, firc_pkg::TCP_FLAG_SYN, 1'b1, 32'h0A01_0203,
			32'hC0A8_0101, 16'd80));
		send_word(make_rule(firc_pkg::PROTO_TCP, 4'd15, 1'b0, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_word(make_pkt(firc_pkg::PROTO_TCP, firc_pkg::TCP_FLAG_SYN, 1'b0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 16'hFFFF));
		wait_drained();

		// Random, sender light and receiver heavy
		repeat (430) send_word(random_word());
		wait_drained();

		// Random, roles swapped
		src_idle_pct  = 64;
		sink_idle_pct = 22;
		repeat (430) send_word(random_word());
		wait_drained();

		// No idling; open with a long receiver hold-off so the input backs up
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_arm <= 1'b1;
		repeat (440) send_word(random_word());
		wait_drained();

		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
